@@ src/lfs_pkg.sv @@
// Shared types and constants for the LED driver frame sequencer.
// Used by every module of the block but lfs_ram; depends on nothing.
package lfs_pkg;

    // Chain size and derived store geometry
    localparam int DEVICES  = 1;
    localparam int CHANNELS = 16 * DEVICES;
    localparam int ADDR_W   = $clog2(CHANNELS);

    // Field widths
    localparam int ACTION_W = 3;
    localparam int CHAN_W   = 4;
    localparam int GRAY_W   = 12;
    localparam int DC_W     = 6;
    localparam int KIND_W   = 3;
    localparam int BYTE_W   = 8;

    // Packing accumulator: room for a leftover nibble plus one new level
    localparam int ACC_W  = 20;
    localparam int BITS_W = 5;

    // Dot-correction ceiling and its reset value
    localparam logic [DC_W-1:0] DC_MAX = {DC_W{1'b1}};

    // Request actions
    localparam logic [ACTION_W-1:0] ACT_WRITE_LEVEL = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_CLEAR_LEVEL = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_WRITE_DC    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_SEND_DC     = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_FRAME_TICK  = 3'd4;

    // Bus event kinds
    localparam logic [KIND_W-1:0] EV_BLANK_ON    = 3'd0;
    localparam logic [KIND_W-1:0] EV_LATCH       = 3'd1;
    localparam logic [KIND_W-1:0] EV_EXTRA_CLOCK = 3'd2;
    localparam logic [KIND_W-1:0] EV_BLANK_OFF   = 3'd3;
    localparam logic [KIND_W-1:0] EV_SHIFT       = 3'd4;

    // Write request from the sequencer to the channel store
    typedef struct packed {
        logic              gray_we;
        logic              dc_we;
        logic              gray_clr;
        logic [ADDR_W-1:0] addr;
        logic [GRAY_W-1:0] value;
    } t_wr;

endpackage

@@ src/lfs_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for both per-channel stores.
module lfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/lfs_store.sv @@
// Per-channel grayscale and dot-correction store: two RAMs with valid bits.
// Depends on lfs_pkg and lfs_ram.
module lfs_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lfs_pkg::t_wr                  i_wr,
    input  logic [lfs_pkg::ADDR_W-1:0]    i_rd_addr,
    output logic [lfs_pkg::GRAY_W-1:0]    o_gray_q,
    output logic [lfs_pkg::DC_W-1:0]      o_dc_q
);

    logic [lfs_pkg::CHANNELS-1:0] r_gray_vld;
    logic [lfs_pkg::CHANNELS-1:0] r_dc_vld;
    logic                         r_gray_rv;
    logic                         r_dc_rv;
    logic [lfs_pkg::DC_W-1:0]     dc_wdata;
    logic [lfs_pkg::GRAY_W-1:0]   gray_ram_q;
    logic [lfs_pkg::DC_W-1:0]     dc_ram_q;

    // Saturate dot correction to its field range
    assign dc_wdata = (|i_wr.value[lfs_pkg::GRAY_W-1:lfs_pkg::DC_W])
                      ? lfs_pkg::DC_MAX : i_wr.value[lfs_pkg::DC_W-1:0];

    lfs_ram #(
        .WIDTH (lfs_pkg::GRAY_W),
        .DEPTH (lfs_pkg::CHANNELS)
    ) u_gray_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr.gray_we),
        .i_waddr (i_wr.addr),
        .i_wdata (i_wr.value),
        .i_raddr (i_rd_addr),
        .o_rdata (gray_ram_q)
    );

    lfs_ram #(
        .WIDTH (lfs_pkg::DC_W),
        .DEPTH (lfs_pkg::CHANNELS)
    ) u_dc_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr.dc_we),
        .i_waddr (i_wr.addr),
        .i_wdata (dc_wdata),
        .i_raddr (i_rd_addr),
        .o_rdata (dc_ram_q)
    );

    // Track written entries; clear drops all grayscale entries at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gray_vld <= '0;
            r_dc_vld   <= '0;
        end else begin
            if (i_wr.gray_clr) begin
                r_gray_vld <= '0;
            end else if (i_wr.gray_we) begin
                r_gray_vld[i_wr.addr] <= 1'b1;
            end
            if (i_wr.dc_we) begin
                r_dc_vld[i_wr.addr] <= 1'b1;
            end
        end
    end

    // Read valid bits alongside the RAM read
    always_ff @(posedge i_clk) begin
        r_gray_rv <= r_gray_vld[i_rd_addr];
        r_dc_rv   <= r_dc_vld[i_rd_addr];
    end

    // Unwritten entries read as their reset values
    assign o_gray_q = r_gray_rv ? gray_ram_q : '0;
    assign o_dc_q   = r_dc_rv ? dc_ram_q : lfs_pkg::DC_MAX;

endmodule

@@ src/lfs_seq.sv @@
// Request sequencer: decodes actions, orders bus events, packs store values
// into bytes and holds the output register. Depends on lfs_pkg.
module lfs_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [lfs_pkg::ACTION_W-1:0]  i_action,
    input  logic [lfs_pkg::CHAN_W-1:0]    i_channel,
    input  logic [lfs_pkg::GRAY_W-1:0]    i_value,
    output lfs_pkg::t_wr                  o_wr,
    output logic [lfs_pkg::ADDR_W-1:0]    o_rd_addr,
    input  logic [lfs_pkg::GRAY_W-1:0]    i_gray_q,
    input  logic [lfs_pkg::DC_W-1:0]      i_dc_q,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [lfs_pkg::KIND_W-1:0]    o_event_kind,
    output logic [lfs_pkg::BYTE_W-1:0]    o_shift_byte,
    output logic                          o_mode_line,
    output logic                          o_source_line,
    output logic                          o_last
);

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_BLANK_ON  = 8'b0000_0010,
        S_LATCH_F   = 8'b0000_0100,
        S_EXTRA     = 8'b0000_1000,
        S_BLANK_OFF = 8'b0001_0000,
        S_PK_ACC    = 8'b0010_0000,
        S_PK_EMIT   = 8'b0100_0000,
        S_LATCH_D   = 8'b1000_0000
    } t_state;

    t_state                       r_state, n_state;
    logic [lfs_pkg::ADDR_W-1:0]   r_rd_ch, n_rd_ch;
    logic [lfs_pkg::ACC_W-1:0]    r_acc, n_acc;
    logic [lfs_pkg::BITS_W-1:0]   r_bits, n_bits;
    logic                         r_final, n_final;
    logic                         r_gray, n_gray;
    logic                         r_extra, n_extra;
    logic                         r_latch_pending, n_latch_pending;
    logic                         r_dc_mode, n_dc_mode;
    logic                         r_dc_source, n_dc_source;

    logic                         r_out_valid;
    logic [lfs_pkg::KIND_W-1:0]   r_kind;
    logic [lfs_pkg::BYTE_W-1:0]   r_byte;
    logic                         r_mode;
    logic                         r_src;
    logic                         r_last;

    logic                         in_acc;
    logic                         out_free;
    logic                         emit;
    logic [lfs_pkg::KIND_W-1:0]   ev_kind;
    logic [lfs_pkg::BYTE_W-1:0]   ev_byte;
    logic                         ev_last;
    logic [lfs_pkg::ACC_W-1:0]    acc_in;
    logic [lfs_pkg::BITS_W-1:0]   bits_in;
    logic [lfs_pkg::BITS_W-1:0]   bits_out;
    logic [lfs_pkg::BYTE_W-1:0]   byte_out;
    lfs_pkg::t_wr                 wr;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Read one channel ahead; wraps from channel 0 to the top channel
    assign o_rd_addr = r_rd_ch - lfs_pkg::ADDR_W'(1);

    // Packing datapath
    assign acc_in   = r_gray ? {r_acc[lfs_pkg::ACC_W-lfs_pkg::GRAY_W-1:0], i_gray_q}
                             : {r_acc[lfs_pkg::ACC_W-lfs_pkg::DC_W-1:0], i_dc_q};
    assign bits_in  = r_bits + (r_gray ? lfs_pkg::BITS_W'(lfs_pkg::GRAY_W)
                                       : lfs_pkg::BITS_W'(lfs_pkg::DC_W));
    assign bits_out = r_bits - lfs_pkg::BITS_W'(lfs_pkg::BYTE_W);
    assign byte_out = lfs_pkg::BYTE_W'(r_acc >> bits_out);

    // Decode requests and step through the event list
    always_comb begin
        n_state         = r_state;
        n_rd_ch         = r_rd_ch;
        n_acc           = r_acc;
        n_bits          = r_bits;
        n_final         = r_final;
        n_gray          = r_gray;
        n_extra         = r_extra;
        n_latch_pending = r_latch_pending;
        n_dc_mode       = r_dc_mode;
        n_dc_source     = r_dc_source;
        emit            = 1'b0;
        ev_kind         = lfs_pkg::EV_BLANK_ON;
        ev_byte         = '0;
        ev_last         = 1'b0;
        wr              = '0;
        wr.addr         = lfs_pkg::ADDR_W'(i_channel);
        wr.value        = i_value;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_action)
                        lfs_pkg::ACT_WRITE_LEVEL: wr.gray_we  = 1'b1;
                        lfs_pkg::ACT_CLEAR_LEVEL: wr.gray_clr = 1'b1;
                        lfs_pkg::ACT_WRITE_DC:    wr.dc_we    = 1'b1;
                        lfs_pkg::ACT_SEND_DC: begin
                            n_dc_mode   = 1'b1;
                            n_dc_source = 1'b1;
                            n_gray      = 1'b0;
                            n_bits      = '0;
                            n_rd_ch     = o_rd_addr;
                            n_state     = S_PK_ACC;
                        end
                        lfs_pkg::ACT_FRAME_TICK: n_state = S_BLANK_ON;
                        default: ;
                    endcase
                end
            end
            S_BLANK_ON: begin
                if (out_free) begin
                    emit      = 1'b1;
                    ev_kind   = lfs_pkg::EV_BLANK_ON;
                    n_extra   = r_dc_mode;
                    n_dc_mode = 1'b0;
                    if (r_latch_pending) begin
                        n_state = S_LATCH_F;
                    end else if (r_dc_mode) begin
                        n_state = S_EXTRA;
                    end else begin
                        n_state = S_BLANK_OFF;
                    end
                end
            end
            S_LATCH_F: begin
                if (out_free) begin
                    emit            = 1'b1;
                    ev_kind         = lfs_pkg::EV_LATCH;
                    n_latch_pending = 1'b0;
                    n_state         = r_extra ? S_EXTRA : S_BLANK_OFF;
                end
            end
            S_EXTRA: begin
                if (out_free) begin
                    emit    = 1'b1;
                    ev_kind = lfs_pkg::EV_EXTRA_CLOCK;
                    n_state = S_BLANK_OFF;
                end
            end
            S_BLANK_OFF: begin
                if (out_free) begin
                    emit    = 1'b1;
                    ev_kind = lfs_pkg::EV_BLANK_OFF;
                    n_gray  = 1'b1;
                    n_bits  = '0;
                    n_rd_ch = o_rd_addr;
                    n_state = S_PK_ACC;
                end
            end
            S_PK_ACC: begin
                // Merge the channel read last cycle into the accumulator
                n_acc   = acc_in;
                n_bits  = bits_in;
                n_final = (r_rd_ch == '0);
                if (bits_in >= lfs_pkg::BITS_W'(lfs_pkg::BYTE_W)) begin
                    n_state = S_PK_EMIT;
                end else begin
                    n_rd_ch = o_rd_addr;
                end
            end
            S_PK_EMIT: begin
                if (out_free) begin
                    emit    = 1'b1;
                    ev_kind = lfs_pkg::EV_SHIFT;
                    ev_byte = byte_out;
                    n_bits  = bits_out;
                    if (bits_out < lfs_pkg::BITS_W'(lfs_pkg::BYTE_W)) begin
                        if (!r_final) begin
                            n_rd_ch = o_rd_addr;
                            n_state = S_PK_ACC;
                        end else if (r_gray) begin
                            ev_last         = 1'b1;
                            n_latch_pending = 1'b1;
                            n_state         = S_IDLE;
                        end else begin
                            n_state = S_LATCH_D;
                        end
                    end
                end
            end
            S_LATCH_D: begin
                if (out_free) begin
                    emit    = 1'b1;
                    ev_kind = lfs_pkg::EV_LATCH;
                    ev_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_wr = wr;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_rd_ch         <= '0;
            r_bits          <= '0;
            r_final         <= 1'b0;
            r_gray          <= 1'b0;
            r_extra         <= 1'b0;
            r_latch_pending <= 1'b0;
            r_dc_mode       <= 1'b1;
            r_dc_source     <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_rd_ch         <= n_rd_ch;
            r_bits          <= n_bits;
            r_final         <= n_final;
            r_gray          <= n_gray;
            r_extra         <= n_extra;
            r_latch_pending <= n_latch_pending;
            r_dc_mode       <= n_dc_mode;
            r_dc_source     <= n_dc_source;
        end
    end

    // Accumulator payload
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    // Output register: load on emit, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind <= ev_kind;
            r_byte <= ev_byte;
            r_mode <= r_dc_mode;
            r_src  <= r_dc_source;
            r_last <= ev_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_kind  = r_kind;
    assign o_shift_byte  = r_byte;
    assign o_mode_line   = r_mode;
    assign o_source_line = r_src;
    assign o_last        = r_last;

endmodule

@@ src/led_driver_frame_sequencer.sv @@
// Top level of the LED driver frame sequencer: channel store plus sequencer.
// Depends on lfs_pkg, lfs_store and lfs_seq.
//
// Usage: the host sends requests (action, channel, value) on a valid/stall
// input channel. Level and dot-correction writes and level clears update the
// per-channel store and produce no events. The input stays open, so the next
// request can be taken on the following cycle. A send dot-correction request
// emits the packed 6-bit values (12 shift bytes per device) and a latch. A
// frame tick emits blank on, an optional latch, an optional extra clock,
// blank off and 24 packed level bytes per device. Events leave on the
// valid/stall output channel, at most one per cycle, and the final one of
// each request is flagged with o_last.
// Timing: the store is read one channel at a time, highest first, and each
// channel is merged into the accumulator in S_PK_ACC before its complete
// bytes go out from S_PK_EMIT, one per cycle while the output is not
// stalled. A frame tick's blank on event is emitted from S_BLANK_ON, the
// state entered when the tick is taken. A dot-correction send emits its
// first byte from S_PK_EMIT once the top two channels have been merged. A
// new request is taken once the last event of the previous one has been
// loaded. Reset clears levels to zero, dot corrections to 63 and the pending
// latch, and sets DC mode, so the next event shows the mode line high. A
// stall on the output holds the current event and freezes the sequence; the
// input stalls until the request completes.
module led_driver_frame_sequencer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [lfs_pkg::ACTION_W-1:0]  i_action,
    input  logic [lfs_pkg::CHAN_W-1:0]    i_channel,
    input  logic [lfs_pkg::GRAY_W-1:0]    i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [lfs_pkg::KIND_W-1:0]    o_event_kind,
    output logic [lfs_pkg::BYTE_W-1:0]    o_shift_byte,
    output logic                          o_mode_line,
    output logic                          o_source_line,
    output logic                          o_last
);

    lfs_pkg::t_wr                 wr;
    logic [lfs_pkg::ADDR_W-1:0]   rd_addr;
    logic [lfs_pkg::GRAY_W-1:0]   gray_q;
    logic [lfs_pkg::DC_W-1:0]     dc_q;

    lfs_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr),
        .i_rd_addr (rd_addr),
        .o_gray_q  (gray_q),
        .o_dc_q    (dc_q)
    );

    lfs_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_channel     (i_channel),
        .i_value       (i_value),
        .o_wr          (wr),
        .o_rd_addr     (rd_addr),
        .i_gray_q      (gray_q),
        .i_dc_q        (dc_q),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_event_kind  (o_event_kind),
        .o_shift_byte  (o_shift_byte),
        .o_mode_line   (o_mode_line),
        .o_source_line (o_source_line),
        .o_last        (o_last)
    );

    // Only shift events carry a data byte
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_kind != lfs_pkg::EV_SHIFT) |-> o_shift_byte == '0)
        else $error("non-shift event carries a data byte");

    // A request still in progress keeps the input stalled
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> o_in_stall)
        else $error("input open while a request is still emitting");

    // The extra clock follows leaving dot-correction mode, so the mode line is low
    a_extra_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_kind == lfs_pkg::EV_EXTRA_CLOCK) |-> !o_mode_line)
        else $error("extra clock shown with mode line high");

    // Store writes happen only when a request is taken
    a_write_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr.gray_we || wr.dc_we || wr.gray_clr |-> i_in_valid && !o_in_stall)
        else $error("store write without an accepted request");

endmodule

@@ verif/lfs_frame_checker.sv @@
// Scoreboard for the LED driver frame sequencer: watches both channels,
// predicts the bus events of every accepted request and compares them.
// Depends on lfs_pkg for field widths, action codes and event kinds.
module lfs_frame_checker
    import lfs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [CHAN_W-1:0]   i_channel,
    input  logic [GRAY_W-1:0]   i_value,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic [KIND_W-1:0]   i_event_kind,
    input  logic [BYTE_W-1:0]   i_shift_byte,
    input  logic                i_mode_line,
    input  logic                i_source_line,
    input  logic                i_last,
    output int                  o_fail_count,
    output int                  o_events_due
);

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic              mode;
        logic              source;
        logic              last;
    } t_bus_event;

    // Predicted driver state
    logic [GRAY_W-1:0] levels [CHANNELS];
    logic [DC_W-1:0]   dots   [CHANNELS];
    logic              latch_due;
    logic              dc_mode;
    logic              dc_source;

    t_bus_event bus_events_due[$];

    function automatic void restore_driver_state();
        for (int ch = 0; ch < CHANNELS; ch++) begin
            levels[ch] = '0;
            dots[ch]   = DC_MAX;
        end
        latch_due = 1'b0;
        dc_mode   = 1'b1;
        dc_source = 1'b0;
        bus_events_due.delete();
    endfunction

    // Queue one event with the mode lines as they stand now
    function automatic void queue_bus_event(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data);
        t_bus_event ev;
        ev.kind   = kind;
        ev.data   = data;
        ev.mode   = dc_mode;
        ev.source = dc_source;
        ev.last   = 1'b0;
        bus_events_due.push_back(ev);
    endfunction

    // Pack all channels, highest first and MSB first, into shift bytes
    function automatic void queue_packed_bytes(bit gray);
        logic [ACC_W-1:0] acc;
        int               bits;
        int               width;
        logic [GRAY_W-1:0] v;
        acc   = '0;
        bits  = 0;
        width = gray ? GRAY_W : DC_W;
        for (int ch = CHANNELS - 1; ch >= 0; ch--) begin
            v    = gray ? levels[ch] : GRAY_W'(dots[ch]);
            acc  = (acc << width) | ACC_W'(v);
            bits += width;
            while (bits >= BYTE_W) begin
                bits -= BYTE_W;
                queue_bus_event(EV_SHIFT, BYTE_W'(acc >> bits));
            end
        end
    endfunction

    function automatic void predict_request(logic [ACTION_W-1:0] action,
                                            logic [CHAN_W-1:0] channel,
                                            logic [GRAY_W-1:0] value);
        int         idx;
        int         depth_before;
        t_bus_event tail;
        idx          = int'(channel) % CHANNELS;
        depth_before = bus_events_due.size();
        unique case (action)
            ACT_WRITE_LEVEL: begin
                levels[idx] = value;
            end
            ACT_CLEAR_LEVEL: begin
                for (int ch = 0; ch < CHANNELS; ch++) levels[ch] = '0;
            end
            ACT_WRITE_DC: begin
                dots[idx] = (value > GRAY_W'(DC_MAX)) ? DC_MAX : value[DC_W-1:0];
            end
            ACT_SEND_DC: begin
                dc_source = 1'b1;
                dc_mode   = 1'b1;
                queue_packed_bytes(1'b0);
                queue_bus_event(EV_LATCH, '0);
            end
            ACT_FRAME_TICK: begin
                // Blank on still shows the old mode; leaving DC mode adds a clock
                queue_bus_event(EV_BLANK_ON, '0);
                if (dc_mode) begin
                    dc_mode = 1'b0;
                    if (latch_due) begin
                        queue_bus_event(EV_LATCH, '0);
                        latch_due = 1'b0;
                    end
                    queue_bus_event(EV_EXTRA_CLOCK, '0);
                end else if (latch_due) begin
                    queue_bus_event(EV_LATCH, '0);
                    latch_due = 1'b0;
                end
                queue_bus_event(EV_BLANK_OFF, '0);
                queue_packed_bytes(1'b1);
                latch_due = 1'b1;
            end
            default: begin
            end
        endcase
        // Flag the final event of this request
        if (bus_events_due.size() > depth_before) begin
            tail      = bus_events_due.pop_back();
            tail.last = 1'b1;
            bus_events_due.push_back(tail);
        end
    endfunction

    function automatic void compare_field(string name, logic [7:0] expected, logic [7:0] actual);
        if (expected !== actual) begin
            $error("%s: expected %0d, got %0d", name, expected, actual);
            o_fail_count++;
        end
    endfunction

    // Check delivered events first, then predict the newly taken request
    always @(posedge i_clk) begin
        t_bus_event want;
        if (!i_rst_n) begin
            restore_driver_state();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (bus_events_due.size() == 0) begin
                    $error("unexpected event: kind %0d byte %0d", i_event_kind, i_shift_byte);
                    o_fail_count++;
                end else begin
                    want = bus_events_due.pop_front();
                    compare_field("event_kind", 8'(want.kind), 8'(i_event_kind));
                    compare_field("shift_byte", want.data, i_shift_byte);
                    compare_field("mode_line", 8'(want.mode), 8'(i_mode_line));
                    compare_field("source_line", 8'(want.source), 8'(i_source_line));
                    compare_field("last", 8'(want.last), 8'(i_last));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_request(i_action, i_channel, i_value);
            end
        end
        o_events_due = bus_events_due.size();
    end

endmodule

@@ verif/led_driver_frame_sequencer_test.sv @@
// Testbench top for the LED driver frame sequencer: clock, reset, request
// stimulus, output stall and the verdict. Depends on lfs_pkg,
// led_driver_frame_sequencer and lfs_frame_checker.
module led_driver_frame_sequencer_test;
    import lfs_pkg::*;

    localparam int RANDOM_REQUESTS = 448;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 40;

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic [ACTION_W-1:0] i_action    = ACT_WRITE_LEVEL;
    logic [CHAN_W-1:0]   i_channel   = '0;
    logic [GRAY_W-1:0]   i_value     = '0;
    logic                i_out_stall = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [KIND_W-1:0]   o_event_kind;
    logic [BYTE_W-1:0]   o_shift_byte;
    logic                o_mode_line;
    logic                o_source_line;
    logic                o_last;

    int fail_count;
    int events_due;
    int send_idle_pct = 21;
    int recv_stall_pct = 59;
    int cycle_count = 0;

    led_driver_frame_sequencer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_channel     (i_channel),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_event_kind  (o_event_kind),
        .o_shift_byte  (o_shift_byte),
        .o_mode_line   (o_mode_line),
        .o_source_line (o_source_line),
        .o_last        (o_last)
    );

    lfs_frame_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_channel     (i_channel),
        .i_value       (i_value),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_event_kind  (o_event_kind),
        .i_shift_byte  (o_shift_byte),
        .i_mode_line   (o_mode_line),
        .i_source_line (o_source_line),
        .i_last        (o_last),
        .o_fail_count  (fail_count),
        .o_events_due  (events_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Random backpressure on the event side
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Idle at random, then hold the request until it is taken
    task automatic send_request(logic [ACTION_W-1:0] action, logic [CHAN_W-1:0] channel,
                                logic [GRAY_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= action;
        i_channel  <= channel;
        i_value    <= value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    function automatic logic [GRAY_W-1:0] pick_value();
        unique case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return GRAY_W'(DC_MAX);
            3:       return GRAY_W'(DC_MAX) + 1'b1;
            4, 5:    return GRAY_W'($urandom_range(127));
            default: return GRAY_W'($urandom_range(4095));
        endcase
    endfunction

    initial begin
        int                  taken;
        int                  roll;
        logic [ACTION_W-1:0] action;

        // Hold reset low at the start, then release it
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: tick from reset leaves DC mode with no latch pending
        send_request(ACT_FRAME_TICK, 4'd0, 12'd0);
        send_request(ACT_WRITE_LEVEL, 4'd0, 12'hFFF);
        send_request(ACT_WRITE_LEVEL, 4'd15, 12'hFFF);
        send_request(ACT_WRITE_LEVEL, 4'd7, 12'hA5A);
        send_request(ACT_WRITE_LEVEL, 4'd8, 12'h5A5);
        send_request(ACT_WRITE_DC, 4'd0, 12'd0);
        send_request(ACT_WRITE_DC, 4'd15, 12'd63);
        send_request(ACT_WRITE_DC, 4'd3, 12'd64);
        send_request(ACT_WRITE_DC, 4'd8, 12'hFFF);
        send_request(ACT_WRITE_DC, 4'd10, 12'd42);
        // Latch pending while out of DC mode
        send_request(ACT_FRAME_TICK, 4'd15, 12'hFFF);
        // DC send keeps the pending latch; the next tick shows the mode change
        send_request(ACT_SEND_DC, 4'd0, 12'd0);
        send_request(ACT_FRAME_TICK, 4'd0, 12'd0);
        // Unknown actions are dropped
        send_request(3'd5, 4'd5, 12'h123);
        send_request(3'd6, 4'd10, 12'hEDC);
        send_request(3'd7, 4'd15, 12'hFFF);
        send_request(ACT_CLEAR_LEVEL, 4'd0, 12'd0);
        send_request(ACT_FRAME_TICK, 4'd0, 12'd0);
        send_request(ACT_SEND_DC, 4'd0, 12'd0);
        send_request(ACT_SEND_DC, 4'd0, 12'd0);
        send_request(ACT_WRITE_LEVEL, 4'd1, 12'h001);
        send_request(ACT_FRAME_TICK, 4'd0, 12'd0);

        // Random: mostly level and DC updates with frequent ticks
        taken = 0;
        while (taken < RANDOM_REQUESTS) begin
            if (taken == RANDOM_REQUESTS / 3) begin
                send_idle_pct  = 59;
                recv_stall_pct = 21;
            end else if (taken == 2 * RANDOM_REQUESTS / 3) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            roll = $urandom_range(99);
            if (roll < 40)      action = ACT_WRITE_LEVEL;
            else if (roll < 55) action = ACT_WRITE_DC;
            else if (roll < 59) action = ACT_CLEAR_LEVEL;
            else if (roll < 68) action = ACT_SEND_DC;
            else if (roll < 94) action = ACT_FRAME_TICK;
            else                action = ACTION_W'($urandom_range(7, 5));
            send_request(action, CHAN_W'($urandom_range(15)), pick_value());
            taken++;
        end
        i_in_valid <= 1'b0;
        // Let the checker predict the last request before watching its count
        @(posedge i_clk);

        // Drain outstanding events, then give the block time to misbehave
        while (events_due != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && events_due == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            if (events_due != 0) $error("%0d expected events never arrived", events_due);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ led_driver_frame_sequencer.f @@
src/lfs_pkg.sv
src/lfs_ram.sv
src/lfs_store.sv
src/lfs_seq.sv
src/led_driver_frame_sequencer.sv
verif/lfs_frame_checker.sv
verif/led_driver_frame_sequencer_test.sv
